@@ rtl/grid_ground_height_filter_top_defines.svh @@
// assertion macros used by the checker file
`ifndef GRID_GROUND_HEIGHT_FILTER_TOP_DEFINES_SVH
`define GRID_GROUND_HEIGHT_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GHF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GHF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ghf_pkg.sv @@
// shared types and constants of the grid ground height filter
package ghf_pkg;

    localparam int CS_W      = 13;
    localparam int HL_W      = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CS_W-1:0] CELL_SIZE_RST = 13'd500;
    localparam int              ORIGIN_RST    = -64000;
    localparam logic [HL_W-1:0] HLIM_RST      = 23'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE    = 2'd0,
        CFG_ORIGIN_X     = 2'd1,
        CFG_ORIGIN_Y     = 2'd2,
        CFG_HEIGHT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_UPDATE   = 1'b0,
        FUNC_CLASSIFY = 1'b1
    } t_func;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_swap;
        logic mem_clear;
        logic mem_read;
        logic resp;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic pt_ok;
    } t_dp_stat;

endpackage

@@ rtl/ghf_if.sv @@
// point and result channel interfaces
interface ghf_pt_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         point_valid;

    modport source (output valid, func, pos_x, pos_y, pos_z, point_valid, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, point_valid, output ready);
endinterface

interface ghf_res_if #(
    parameter int COORD_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic                       keep;
    logic [1:0]                 status;
    logic signed [COORD_BITS:0] height_above;

    modport source (output valid, keep, status, height_above, input ready);
    modport sink   (input valid, keep, status, height_above, output ready);
endinterface

@@ rtl/ghf_ctrl.sv @@
// sequencing state machine of the ground height filter
module ghf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ghf_pkg::t_dp_stat i_stat,
    output ghf_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIVX  = 6'b000100,
        S_DIVY  = 6'b001000,
        S_LOOK  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    // result register is free or being drained this cycle
    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (!i_stat.pt_ok) begin
                    n_state = S_RESP;
                end else if (i_stat.div_last) begin
                    o_cmd.div_swap = 1'b1;
                    n_state        = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (can_load) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_out_valid = o_cmd.resp || (r_out_valid && !i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/ghf_datapath.sv @@
// config registers, shared cell divider, cell memory and result register
module ghf_datapath #(
    parameter int GRID_X     = 256,
    parameter int GRID_Y     = 256,
    parameter int COORD_BITS = 24,
    localparam int CFG_W     = (COORD_BITS > ghf_pkg::HL_W) ? COORD_BITS : ghf_pkg::HL_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ghf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_func,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_point_valid,
    input  ghf_pkg::t_dp_cmd             i_cmd,
    output ghf_pkg::t_dp_stat            o_stat,
    output logic                         o_keep,
    output logic [1:0]                   o_status,
    output logic signed [COORD_BITS:0]   o_height_above
);

    localparam int CS_W  = ghf_pkg::CS_W;
    localparam int HL_W  = ghf_pkg::HL_W;
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int ITERS = (COORD_BITS + 1) / 2;
    localparam int DW    = 2 * ITERS;
    localparam int IW    = $clog2(ITERS);
    localparam int MW    = COORD_BITS + 1;
    localparam int CMPW  = ((COORD_BITS + 1 > HL_W) ? COORD_BITS + 1 : HL_W) + 1;

    // configuration
    logic [CS_W-1:0]              r_cell_size;
    logic signed [COORD_BITS-1:0] r_origin_x;
    logic signed [COORD_BITS-1:0] r_origin_y;
    logic [HL_W-1:0]              r_height_limit;
    logic [CS_W-1:0]              cs_eff;

    // captured point
    logic                         r_func;
    logic                         r_valid;
    logic signed [COORD_BITS-1:0] r_pz;
    logic                         r_neg_x;
    logic                         r_neg_y;
    logic [COORD_BITS-1:0]        r_y_mag;

    // divider
    logic [DW-1:0]   r_dvd, n_dvd;
    logic [DW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_qx;
    logic [CS_W-1:0] r_rem, n_rem;
    logic [IW-1:0]   r_cnt;
    logic [CS_W:0]   t1, t2, r1;
    logic            q1, q2;

    // cell memory, msb marks a filled cell
    logic [MW-1:0]   mem [DEPTH];
    logic [MW-1:0]   r_rd;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   r_clr;
    logic            r_in_win;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [MW-1:0]   mem_wdata;

    // result
    logic signed [COORD_BITS:0]   x_diff, y_diff;
    logic                         filled;
    logic signed [COORD_BITS-1:0] lowest;
    logic signed [COORD_BITS:0]   h_diff;
    logic signed [CMPW-1:0]       h_ext, hl_ext;
    logic                         upd_write;
    logic                         classify_ok;
    ghf_pkg::t_status             n_status;
    logic                         r_keep;
    ghf_pkg::t_status             r_status;
    logic signed [COORD_BITS:0]   r_height;

    assign cs_eff = (r_cell_size == '0) ? CS_W'(1) : r_cell_size;

    assign x_diff = {i_pos_x[COORD_BITS-1], i_pos_x} - {r_origin_x[COORD_BITS-1], r_origin_x};
    assign y_diff = {i_pos_y[COORD_BITS-1], i_pos_y} - {r_origin_y[COORD_BITS-1], r_origin_y};

    // two restoring division steps per cycle
    always_comb begin
        t1    = {r_rem, r_dvd[DW-1]};
        q1    = (t1 >= {1'b0, cs_eff});
        r1    = q1 ? (t1 - {1'b0, cs_eff}) : t1;
        t2    = {r1[CS_W-1:0], r_dvd[DW-2]};
        q2    = (t2 >= {1'b0, cs_eff});
        n_rem = q2 ? CS_W'(t2 - {1'b0, cs_eff}) : t2[CS_W-1:0];
        n_dvd = {r_dvd[DW-3:0], 2'b00};
        n_quo = {r_quo[DW-3:0], q1, q2};
    end

    assign rd_addr = {r_quo[YW-1:0], r_qx[XW-1:0]};

    // read-modify-write and result selection
    always_comb begin
        filled      = r_rd[MW-1];
        lowest      = r_rd[COORD_BITS-1:0];
        h_diff      = {r_pz[COORD_BITS-1], r_pz} - {lowest[COORD_BITS-1], lowest};
        h_ext       = CMPW'(h_diff);
        hl_ext      = $signed(CMPW'(r_height_limit));
        upd_write   = r_valid && r_in_win && (r_func == ghf_pkg::FUNC_UPDATE)
                      && (!filled || (r_pz < lowest));
        classify_ok = r_valid && r_in_win && (r_func == ghf_pkg::FUNC_CLASSIFY) && filled;
        if (!r_valid) begin
            n_status = ghf_pkg::ST_INVALID;
        end else if (!r_in_win) begin
            n_status = ghf_pkg::ST_OUTSIDE;
        end else if (r_func == ghf_pkg::FUNC_UPDATE) begin
            n_status = ghf_pkg::ST_DONE;
        end else if (!filled) begin
            n_status = ghf_pkg::ST_EMPTY;
        end else begin
            n_status = ghf_pkg::ST_DONE;
        end
    end

    assign mem_we    = i_cmd.mem_clear || (i_cmd.resp && upd_write);
    assign mem_waddr = i_cmd.mem_clear ? r_clr : r_addr;
    assign mem_wdata = i_cmd.mem_clear ? '0 : {1'b1, r_pz};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_read) begin
            r_rd <= mem[rd_addr];
        end
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size    <= ghf_pkg::CELL_SIZE_RST;
            r_origin_x     <= COORD_BITS'(ghf_pkg::ORIGIN_RST);
            r_origin_y     <= COORD_BITS'(ghf_pkg::ORIGIN_RST);
            r_height_limit <= ghf_pkg::HLIM_RST;
            r_clr          <= '0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (ghf_pkg::t_cfg_idx'(i_cfg_idx))
                    ghf_pkg::CFG_CELL_SIZE:    r_cell_size    <= i_cfg_data[CS_W-1:0];
                    ghf_pkg::CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data[COORD_BITS-1:0];
                    ghf_pkg::CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[COORD_BITS-1:0];
                    ghf_pkg::CFG_HEIGHT_LIMIT: r_height_limit <= i_cfg_data[HL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mem_clear) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load || i_cmd.div_swap) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + IW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_valid <= i_point_valid;
            r_pz    <= i_pos_z;
            r_neg_x <= x_diff[COORD_BITS];
            r_neg_y <= y_diff[COORD_BITS];
            r_y_mag <= y_diff[COORD_BITS-1:0];
            r_dvd   <= DW'(x_diff[COORD_BITS-1:0]);
            r_rem   <= '0;
            r_quo   <= '0;
        end else if (i_cmd.div_swap) begin
            // x quotient done, restart on y
            r_qx  <= n_quo;
            r_dvd <= DW'(r_y_mag);
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.mem_read) begin
            r_addr   <= rd_addr;
            r_in_win <= !r_neg_x && !r_neg_y
                        && (r_qx < DW'(GRID_X)) && (r_quo < DW'(GRID_Y));
        end
        if (i_cmd.resp) begin
            r_keep   <= classify_ok && (h_ext <= hl_ext);
            r_status <= n_status;
            r_height <= classify_ok ? h_diff : '0;
        end
    end

    assign o_stat.clr_last = &r_clr;
    assign o_stat.div_last = (r_cnt == IW'(ITERS - 1));
    assign o_stat.pt_ok    = r_valid;

    assign o_keep         = r_keep;
    assign o_status       = r_status;
    assign o_height_above = r_height;

endmodule

@@ rtl/grid_ground_height_filter_top.sv @@
// top level of the grid ground height filter
// Each point is binned into an XY cell by flooring (coordinate - origin) / cell_size on
// both axes with one shared radix-4 divider, then the cell's stored lowest z is read,
// and in update mode lowered, in classify mode compared against height_limit. A valid
// point passes through an accept step, the x-axis and then the y-axis divider steps,
// a memory read and a result/write-back step, which waits while the output register
// still holds an undrained result; a point flagged invalid goes from the first divider
// step straight to the result. No new point is accepted before the result step ends.
// The result sits in an output register, so the next point is taken while it waits.
// After reset the cell memory is cleared one entry per cycle; no point is accepted
// during that pass but configuration writes are. Configuration should only be
// written while no point is in flight.
module grid_ground_height_filter_top #(
    parameter int GRID_X     = 256,
    parameter int GRID_Y     = 256,
    parameter int COORD_BITS = 24,
    localparam int CFG_W     = (COORD_BITS > ghf_pkg::HL_W) ? COORD_BITS : ghf_pkg::HL_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ghf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    ghf_pt_if.sink                        i_pt,
    ghf_res_if.source                     o_res
);

    ghf_pkg::t_dp_cmd  cmd;
    ghf_pkg::t_dp_stat stat;

    ghf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ghf_datapath #(
        .GRID_X     (GRID_X),
        .GRID_Y     (GRID_Y),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_pt.func),
        .i_pos_x        (i_pt.pos_x),
        .i_pos_y        (i_pt.pos_y),
        .i_pos_z        (i_pt.pos_z),
        .i_point_valid  (i_pt.point_valid),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_keep         (o_res.keep),
        .o_status       (o_res.status),
        .o_height_above (o_res.height_above)
    );

endmodule

@@ rtl/ghf_checker.sv @@
// port-level checks of the ground height filter, bound to the top level
`include "grid_ground_height_filter_top_defines.svh"

module ghf_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_keep,
    input logic [1:0]                 i_status,
    input logic signed [COORD_BITS:0] i_height_above
);

    // a stalled result keeps its payload
    `GHF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_keep) && $stable(i_status) && $stable(i_height_above), "result changed while stalled")

    // one point at a time: busy right after a transaction
    `GHF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "point accepted while busy")

    // only a completed classification can keep a point
    `GHF_ASSERT_SAME(a_keep_done, i_out_valid && i_keep, i_status == ghf_pkg::ST_DONE, "keep with non-done status")

    // failed items carry no height and no keep
    `GHF_ASSERT_SAME(a_fail_zero, i_out_valid && (i_status != ghf_pkg::ST_DONE), !i_keep && (i_height_above == '0), "failed result not zeroed")

endmodule

bind grid_ground_height_filter_top ghf_checker #(
    .COORD_BITS (COORD_BITS)
) u_ghf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pt.valid),
    .i_in_ready     (i_pt.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_keep         (o_res.keep),
    .i_status       (o_res.status),
    .i_height_above (o_res.height_above)
);

@@ tb/grid_ground_height_filter_top_test.sv @@
// self-checking testbench for the grid ground height filter top level
`timescale 1ns / 1ps

module grid_ground_height_filter_top_test;

    localparam int GRID_X      = 256;
    localparam int GRID_Y      = 256;
    localparam int COORD_BITS  = 24;
    localparam int CELLS       = GRID_X * GRID_Y;
    localparam int CS_W        = ghf_pkg::CS_W;
    localparam int HL_W        = ghf_pkg::HL_W;
    localparam int CFG_W       = (COORD_BITS > HL_W) ? COORD_BITS : HL_W;
    localparam int POOL        = 8;
    localparam int STALL_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        ghf_pkg::t_func               func;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic                         point_valid;
    } t_pt_item;

    typedef struct {
        logic                       keep;
        ghf_pkg::t_status           status;
        logic signed [COORD_BITS:0] height_above;
    } t_ground_res;

    typedef struct {
        logic [CS_W-1:0] cs;
        longint          ox;
        longint          oy;
        logic [HL_W-1:0] hl;
        int              n;
    } t_phase;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    ghf_pkg::t_cfg_idx     cfg_idx;
    logic [CFG_W-1:0]      cfg_data;

    ghf_pt_if  #(.COORD_BITS(COORD_BITS)) pt_ch ();
    ghf_res_if #(.COORD_BITS(COORD_BITS)) res_ch ();

    grid_ground_height_filter_top #(
        .GRID_X    (GRID_X),
        .GRID_Y    (GRID_Y),
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pt      (pt_ch),
        .o_res     (res_ch)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mirror of the block's configuration and cell store
    logic [CS_W-1:0]              cfg_cell_size    = ghf_pkg::CELL_SIZE_RST;
    logic signed [COORD_BITS-1:0] cfg_origin_x     = COORD_BITS'(ghf_pkg::ORIGIN_RST);
    logic signed [COORD_BITS-1:0] cfg_origin_y     = COORD_BITS'(ghf_pkg::ORIGIN_RST);
    logic [HL_W-1:0]              cfg_height_limit = ghf_pkg::HLIM_RST;
    bit                           cell_filled [CELLS];
    logic signed [COORD_BITS-1:0] cell_lowest [CELLS];

    t_pt_item    pt_pending [$];
    t_ground_res expected_res [$];
    t_pt_item    cur_pt;

    longint pool_ix [POOL];
    longint pool_iy [POOL];
    longint pool_z  [POOL];
    t_phase plan    [PHASES];

    int pt_idle, pt_calm, rdy_hold, rdy_calm, res_seen, err_cnt, stall_cnt;
    bit long_hold_done;

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // bins the point into its cell and updates or grades it against the cell ground
    function automatic t_ground_res classify_point(t_pt_item p);
        t_ground_res r;
        longint      cs, ix, iy, diff;
        int          addr;
        r.keep         = 1'b0;
        r.status       = ghf_pkg::ST_DONE;
        r.height_above = '0;
        cs = (cfg_cell_size == 0) ? 1 : longint'(cfg_cell_size);
        if (!p.point_valid) begin
            r.status = ghf_pkg::ST_INVALID;
            return r;
        end
        ix = floor_div(longint'(p.pos_x) - longint'(cfg_origin_x), cs);
        iy = floor_div(longint'(p.pos_y) - longint'(cfg_origin_y), cs);
        if (ix < 0 || ix >= GRID_X || iy < 0 || iy >= GRID_Y) begin
            r.status = ghf_pkg::ST_OUTSIDE;
            return r;
        end
        addr = int'(iy * GRID_X + ix);
        if (p.func == ghf_pkg::FUNC_UPDATE) begin
            if (!cell_filled[addr] || p.pos_z < cell_lowest[addr]) begin
                cell_lowest[addr] = p.pos_z;
                cell_filled[addr] = 1'b1;
            end
            return r;
        end
        if (!cell_filled[addr]) begin
            r.status = ghf_pkg::ST_EMPTY;
            return r;
        end
        diff = longint'(p.pos_z) - longint'(cell_lowest[addr]);
        r.keep         = (diff <= longint'(cfg_height_limit));
        r.height_above = diff[COORD_BITS:0];
        return r;
    endfunction

    function automatic t_pt_item mk_pt(ghf_pkg::t_func f, longint x, longint y, longint z,
                                       logic v);
        t_pt_item p;
        p.func        = f;
        p.pos_x       = x[COORD_BITS-1:0];
        p.pos_y       = y[COORD_BITS-1:0];
        p.pos_z       = z[COORD_BITS-1:0];
        p.point_valid = v;
        return p;
    endfunction

    task automatic add_pt(t_pt_item p);
        pt_pending = {pt_pending, p};
    endtask

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint z);
        if (z > COORD_MAX) z = COORD_MAX;
        else if (z < COORD_MIN) z = COORD_MIN;
        return z[COORD_BITS-1:0];
    endfunction

    // coordinate inside cell ix, or the fallback when that coordinate does not fit in COORD_BITS
    function automatic logic signed [COORD_BITS-1:0] cell_coord(
        longint ix, longint org, longint cs, logic signed [COORD_BITS-1:0] fallback);
        longint c, off;
        case ($urandom_range(0, 3))
            0:       off = 0;
            1:       off = cs - 1;
            default: off = longint'($urandom_range(0, int'(cs - 1)));
        endcase
        c = org + ix * cs + off;
        if (c > COORD_MAX || c < COORD_MIN) return fallback;
        return c[COORD_BITS-1:0];
    endfunction

    function automatic t_pt_item random_point();
        t_pt_item p;
        int       r, k;
        longint   cs, z, past;
        r  = $urandom_range(0, 99);
        k  = $urandom_range(0, POOL - 1);
        cs = (cfg_cell_size == 0) ? 1 : longint'(cfg_cell_size);
        p.func        = ghf_pkg::t_func'($urandom_range(0, 1));
        p.point_valid = 1'b1;
        p.pos_x       = COORD_BITS'($urandom);
        p.pos_y       = COORD_BITS'($urandom);
        p.pos_z       = COORD_BITS'($urandom);
        if (r < 72) begin
            p.func  = ($urandom_range(0, 9) < 4) ? ghf_pkg::FUNC_UPDATE
                                                 : ghf_pkg::FUNC_CLASSIFY;
            p.pos_x = cell_coord(pool_ix[k], longint'(cfg_origin_x), cs, p.pos_x);
            p.pos_y = cell_coord(pool_iy[k], longint'(cfg_origin_y), cs, p.pos_y);
            case ($urandom_range(0, 3))
                // within one of the height limit
                0: z = pool_z[k] + longint'(cfg_height_limit)
                       + longint'($urandom_range(0, 2)) - 1;
                1: z = pool_z[k] - longint'($urandom_range(0, 3000));
                default: z = pool_z[k] + longint'($urandom_range(0, 6000));
            endcase
            p.pos_z = clamp_coord(z);
        end else if (r < 80) begin
            p.point_valid = 1'b0;
        end else if (r < 90) begin
            // one axis just past the window edge
            p.pos_x = cell_coord(pool_ix[k], longint'(cfg_origin_x), cs, p.pos_x);
            p.pos_y = cell_coord(pool_iy[k], longint'(cfg_origin_y), cs, p.pos_y);
            if ($urandom_range(0, 1) != 0) begin
                past    = ($urandom_range(0, 1) != 0) ? -1 : GRID_X;
                p.pos_x = cell_coord(past, longint'(cfg_origin_x), cs, p.pos_x);
            end else begin
                past    = ($urandom_range(0, 1) != 0) ? -1 : GRID_Y;
                p.pos_y = cell_coord(past, longint'(cfg_origin_y), cs, p.pos_y);
            end
        end
        return p;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int idle_cycles(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 4) begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 980) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic write_reg(ghf_pkg::t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            ghf_pkg::CFG_CELL_SIZE:    cfg_cell_size    = data[CS_W-1:0];
            ghf_pkg::CFG_ORIGIN_X:     cfg_origin_x     = data[COORD_BITS-1:0];
            ghf_pkg::CFG_ORIGIN_Y:     cfg_origin_y     = data[COORD_BITS-1:0];
            ghf_pkg::CFG_HEIGHT_LIMIT: cfg_height_limit = data[HL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pt_pending.size() != 0 || pt_ch.valid || expected_res.size() != 0);
    endtask

    // point driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_ch.valid <= 1'b0;
        end else begin
            if (pt_ch.valid && pt_ch.ready) begin
                expected_res = {expected_res, classify_point(cur_pt)};
                pt_idle = idle_cycles(pt_calm);
            end
            if (!(pt_ch.valid && !pt_ch.ready)) begin
                if (pt_idle > 0) begin
                    pt_idle--;
                    pt_ch.valid <= 1'b0;
                end else if (pt_pending.size() != 0) begin
                    cur_pt = pt_pending.pop_front();
                    pt_ch.func        <= cur_pt.func;
                    pt_ch.pos_x       <= cur_pt.pos_x;
                    pt_ch.pos_y       <= cur_pt.pos_y;
                    pt_ch.pos_z       <= cur_pt.pos_z;
                    pt_ch.point_valid <= cur_pt.point_valid;
                    pt_ch.valid       <= 1'b1;
                end else begin
                    pt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready generator
    always @(posedge clk) begin
        t_ground_res want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                res_seen++;
                if (expected_res.size() == 0) begin
                    if (err_cnt < 40)
                        $display("%0t: unexpected transaction, got keep %0d st %0d h %0d",
                                 $time, res_ch.keep, res_ch.status, res_ch.height_above);
                    err_cnt++;
                end else begin
                    want = expected_res.pop_front();
                    if (res_ch.keep !== want.keep || res_ch.status !== want.status ||
                        res_ch.height_above !== want.height_above) begin
                        if (err_cnt < 40)
                            $display("%0t: exp keep %0d st %0d h %0d, got %0d %0d %0d",
                                     $time, want.keep, want.status, want.height_above,
                                     res_ch.keep, res_ch.status, res_ch.height_above);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!long_hold_done && res_seen == 300) begin
                long_hold_done = 1'b1;
                rdy_hold       = 600;
            end
            if (rdy_hold > 0) begin
                rdy_hold--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                rdy_hold = idle_cycles(rdy_calm);
            end
        end
    end

    always @(posedge clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = ghf_pkg::CFG_CELL_SIZE;
        cfg_data          = '0;
        pt_ch.valid       = 1'b0;
        pt_ch.func        = ghf_pkg::FUNC_UPDATE;
        pt_ch.pos_x       = '0;
        pt_ch.pos_y       = '0;
        pt_ch.pos_z       = '0;
        pt_ch.point_valid = 1'b0;
        res_ch.ready      = 1'b0;
        pt_idle = 0; pt_calm = 0; rdy_hold = 0; rdy_calm = 0;
        res_seen = 0; err_cnt = 0; stall_cnt = 0; long_hold_done = 1'b0;

        plan[0] = '{13'd100,  -12800,   -12800,   23'd1500,    200};
        plan[1] = '{13'd5000, -640000,  -640000,  23'd8388607, 200};
        plan[2] = '{13'd0,    0,        -128,     23'd0,       160};
        plan[3] = '{13'd8191, COORD_MIN, COORD_MIN, 23'd1,     180};
        plan[4] = '{13'd1,    COORD_MAX, COORD_MAX, 23'd8388607, 60};
        plan[5] = '{13'd0,    0,        0,        23'd0,       200};
        plan[6] = '{ghf_pkg::CELL_SIZE_RST, ghf_pkg::ORIGIN_RST, ghf_pkg::ORIGIN_RST,
                    ghf_pkg::HLIM_RST, 200};
        plan[7] = '{13'd300,  -38400,   -38400,   23'd250,     120};
        plan[5].cs = CS_W'($urandom_range(100, 5000));
        plan[5].ox = longint'($urandom_range(0, 8000000)) - 4000000;
        plan[5].oy = longint'($urandom_range(0, 8000000)) - 4000000;
        plan[5].hl = HL_W'($urandom_range(1, 20000));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at the reset configuration, taken once the store clear ends
        @(negedge clk);
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, COORD_MAX, COORD_MIN, 0, 1'b0));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -64000, -64000, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, -64000, -64000, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -63501, -63501, 1500, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -63600, -63999, 1501, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, -63800, -63800, -100, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, -63800, -63800, 50, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -63999, -63999, -100, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, 63999, 63999, COORD_MIN, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, 63500, 63500, COORD_MAX, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, 64000, 0, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -64001, 0, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, 0, 64000, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, 0, -64001, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, COORD_MIN, COORD_MIN, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, COORD_MAX, COORD_MAX, 0, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, 0, 0, COORD_MAX, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, 499, 499, COORD_MIN, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_UPDATE, 0, 0, 8388600, 1'b1));
        add_pt(mk_pt(ghf_pkg::FUNC_CLASSIFY, -1, -1, 0, 1'b1));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            pool_ix[0] = 0;
            pool_iy[0] = 0;
            pool_ix[1] = GRID_X - 1;
            pool_iy[1] = GRID_Y - 1;
            for (int k = 2; k < POOL; k++) begin
                pool_ix[k] = $urandom_range(0, GRID_X - 1);
                pool_iy[k] = $urandom_range(0, GRID_Y - 1);
            end
            for (int k = 0; k < POOL; k++)
                pool_z[k] = longint'($urandom_range(0, 4000000)) - 2000000;

            write_reg(ghf_pkg::CFG_CELL_SIZE, CFG_W'(plan[ph].cs));
            write_reg(ghf_pkg::CFG_ORIGIN_X, plan[ph].ox[CFG_W-1:0]);
            write_reg(ghf_pkg::CFG_ORIGIN_Y, plan[ph].oy[CFG_W-1:0]);
            write_reg(ghf_pkg::CFG_HEIGHT_LIMIT, CFG_W'(plan[ph].hl));
            @(posedge clk);
            cfg_we <= 1'b0;

            @(negedge clk);
            for (int i = 0; i < plan[ph].n; i++)
                add_pt(random_point());
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
